// ===== hw/rtl/json_bracket_balance_checker_assert.svh =====
// ---------------------------------------------------------------------------
// JSON bracket balance checker assertion macros
// Shared concurrent-assertion wrappers, clocked on clk.
// ---------------------------------------------------------------------------
`ifndef JSON_BRACKET_BALANCE_CHECKER_ASSERT_SVH
`define JSON_BRACKET_BALANCE_CHECKER_ASSERT_SVH

// Checked only out of reset.
`define JBB_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define JBB_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== hw/rtl/jbb_pkg.sv =====
// ---------------------------------------------------------------------------
// jbb_pkg
// Byte codes, token kinds and inter-module structs for the bracket checker.
// ---------------------------------------------------------------------------
`default_nettype none

package jbb_pkg;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;

  typedef enum logic [2:0] {
    TOK_OTHER,
    TOK_QUOTE,
    TOK_BSLASH,
    TOK_LBRACE,
    TOK_RBRACE,
    TOK_LBRACK,
    TOK_RBRACK
  } tok_kind_t;

  // classified byte handed to the tracker
  typedef struct packed {
    logic      take;
    tok_kind_t kind;
    logic      last;
  } tok_t;

  // end-of-text verdict handed to the output stage
  typedef struct packed {
    logic fire;
    logic is_valid;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/jbb_if.sv =====
// ---------------------------------------------------------------------------
// jbb_if
// Valid/ready channel interfaces for text bytes and verdicts.
// ---------------------------------------------------------------------------
`default_nettype none

interface jbb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_byte;

  modport source (output valid, output char_in, output last_byte, input ready);
  modport sink   (input valid, input char_in, input last_byte, output ready);
endinterface

interface jbb_out_if;
  logic valid;
  logic ready;
  logic is_valid;

  modport source (output valid, output is_valid, input ready);
  modport sink   (input valid, input is_valid, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/jbb_classify.sv =====
// ---------------------------------------------------------------------------
// jbb_classify
// Decodes one text byte into a token kind.
// ---------------------------------------------------------------------------
`default_nettype none

module jbb_classify (
  input  wire logic        take,
  input  wire logic [7:0]  char_in,
  input  wire logic        last_byte,
  output jbb_pkg::tok_t    tok
);

  always_comb begin
    tok.take = take;
    tok.last = last_byte;
    unique case (char_in)
      jbb_pkg::CH_QUOTE:     tok.kind = jbb_pkg::TOK_QUOTE;
      jbb_pkg::CH_BACKSLASH: tok.kind = jbb_pkg::TOK_BSLASH;
      jbb_pkg::CH_LBRACE:    tok.kind = jbb_pkg::TOK_LBRACE;
      jbb_pkg::CH_RBRACE:    tok.kind = jbb_pkg::TOK_RBRACE;
      jbb_pkg::CH_LBRACKET:  tok.kind = jbb_pkg::TOK_LBRACK;
      jbb_pkg::CH_RBRACKET:  tok.kind = jbb_pkg::TOK_RBRACK;
      default:               tok.kind = jbb_pkg::TOK_OTHER;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/jbb_track.sv =====
// ---------------------------------------------------------------------------
// jbb_track
// String/escape flags, nesting counters and sticky failure; emits verdict.
// ---------------------------------------------------------------------------
`default_nettype none

module jbb_track #(
  parameter int DEPTH_BITS = 8
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  jbb_pkg::tok_t  tok,
  output jbb_pkg::res_t  res
);

  localparam logic [DEPTH_BITS-1:0] LVL_ONE = DEPTH_BITS'(1);
  localparam logic [DEPTH_BITS-1:0] LVL_MAX = {DEPTH_BITS{1'b1}};

  logic                  in_str_r,  in_str_nxt;
  logic                  esc_r,     esc_nxt;
  logic                  fail_r,    fail_nxt;
  logic [DEPTH_BITS-1:0] brace_r,   brace_nxt;
  logic [DEPTH_BITS-1:0] brack_r,   brack_nxt;

  always_comb begin
    in_str_nxt = in_str_r;
    esc_nxt    = esc_r;
    fail_nxt   = fail_r;
    brace_nxt  = brace_r;
    brack_nxt  = brack_r;

    if (in_str_r) begin
      if (esc_r) begin
        esc_nxt = 1'b0;
      end else if (tok.kind == jbb_pkg::TOK_BSLASH) begin
        esc_nxt = 1'b1;
      end else if (tok.kind == jbb_pkg::TOK_QUOTE) begin
        in_str_nxt = 1'b0;
      end
    end else begin
      case (tok.kind)
        jbb_pkg::TOK_QUOTE: begin
          in_str_nxt = 1'b1;
          esc_nxt    = 1'b0;
        end
        jbb_pkg::TOK_LBRACE: begin
          if (brace_r == LVL_MAX) fail_nxt = 1'b1;
          else                    brace_nxt = brace_r + LVL_ONE;
        end
        jbb_pkg::TOK_RBRACE: begin
          if (brace_r == '0) fail_nxt = 1'b1;
          else               brace_nxt = brace_r - LVL_ONE;
        end
        jbb_pkg::TOK_LBRACK: begin
          if (brack_r == LVL_MAX) fail_nxt = 1'b1;
          else                    brack_nxt = brack_r + LVL_ONE;
        end
        jbb_pkg::TOK_RBRACK: begin
          if (brack_r == '0) fail_nxt = 1'b1;
          else               brack_nxt = brack_r - LVL_ONE;
        end
        default: begin
        end
      endcase
    end

    res.fire     = tok.take && tok.last;
    res.is_valid = !fail_nxt && !in_str_nxt && (brace_nxt == '0) && (brack_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (tok.take && tok.last)) begin
      in_str_r <= 1'b0;
      esc_r    <= 1'b0;
      fail_r   <= 1'b0;
      brace_r  <= '0;
      brack_r  <= '0;
    end else if (tok.take) begin
      in_str_r <= in_str_nxt;
      esc_r    <= esc_nxt;
      fail_r   <= fail_nxt;
      brace_r  <= brace_nxt;
      brack_r  <= brack_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/jbb_out_stage.sv =====
// ---------------------------------------------------------------------------
// jbb_out_stage
// Result register holding one verdict until the sink takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module jbb_out_stage (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  jbb_pkg::res_t  res,
  output logic           slot_free,
  jbb_out_if.source      out_chan
);

  logic valid_r;
  logic is_valid_r;

  assign slot_free         = !valid_r || out_chan.ready;
  assign out_chan.valid    = valid_r;
  assign out_chan.is_valid = is_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res.fire) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.fire) begin
      is_valid_r <= res.is_valid;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/json_bracket_balance_checker.sv =====
// ---------------------------------------------------------------------------
// json_bracket_balance_checker
// Streaming brace/bracket/string balance check over a JSON text.
// ---------------------------------------------------------------------------
// Feed the text one byte per item on in_chan, with last_byte set on the
// final byte. A new byte is taken every cycle; the only thing that can
// hold in_chan.ready low is a verdict still sitting in the single output
// register with out_chan.ready low. The last byte's verdict shows on
// out_chan in the cycle after it is taken, and the tracker is back at its
// reset state for the next text at once. Bytes without last_byte produce
// no item. Inside double-quoted strings braces and brackets are ignored
// and a backslash escapes the byte after it. A closer at level zero, or
// an opener past 2^DEPTH_BITS-1 open levels, marks the text invalid; no
// later byte of that text clears it.
// ---------------------------------------------------------------------------
`default_nettype none

module json_bracket_balance_checker #(
  parameter int DEPTH_BITS = 8   // nesting counter width, 2..32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  jbb_in_if.sink     in_chan,
  jbb_out_if.source  out_chan
);

  jbb_pkg::tok_t tok;
  jbb_pkg::res_t res;
  logic          slot_free;
  logic          take;

  // accept whenever the output register is empty or draining this cycle
  assign in_chan.ready = slot_free;
  assign take          = in_chan.valid && slot_free;

  jbb_classify u_classify (
    .take      (take),
    .char_in   (in_chan.char_in),
    .last_byte (in_chan.last_byte),
    .tok       (tok)
  );

  // state registers; verdict computed from the post-byte state
  jbb_track #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .tok   (tok),
    .res   (res)
  );

  jbb_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .slot_free (slot_free),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/jbb_checker.sv =====
// ---------------------------------------------------------------------------
// jbb_checker
// Port-level assertions for the bracket checker, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "json_bracket_balance_checker_assert.svh"

module jbb_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_last,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_is_valid
);

  logic in_take;
  logic out_stall;

  assign in_take   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  `JBB_ASSERT_RUN(a_out_hold, out_stall |=> out_valid && $stable(out_is_valid), "verdict not held")

  `JBB_ASSERT_RUN(a_last_gives_item, in_take && in_last |=> out_valid, "no verdict after last byte")

  `JBB_ASSERT_RUN(a_body_no_item, in_take && !in_last |=> !out_valid, "verdict for non-final byte")

  `JBB_ASSERT_RUN(a_full_blocks_in, out_stall |-> !in_ready, "byte taken while verdict held")

  `JBB_ASSERT_ALL(a_reset_clears, !rst_n |=> !out_valid, "verdict valid right after reset")

endmodule

bind json_bracket_balance_checker jbb_checker u_jbb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .in_last      (in_chan.last_byte),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_is_valid (out_chan.is_valid)
);

`default_nettype wire

// ===== tb/json_bracket_balance_checker_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// json_bracket_balance_checker_tb
// Self-checking bench: random and directed JSON-like texts, one verdict each.
// ---------------------------------------------------------------------------
// Texts are fed byte by byte on in_chan. A scoreboard class tracks string,
// escape, brace and bracket state as each byte is accepted and queues the
// verdict expected when the last byte goes in. Verdicts on out_chan are
// popped and compared in order. The sender runs in bursts and the receiver
// stalls on a changing pattern of its own.
// ---------------------------------------------------------------------------

module json_bracket_balance_checker_tb;

  localparam int LVL_BITS    = 8;    // nesting counter width of the DUT
  localparam int RAND_BYTES  = 300;  // random-phase stop point, in items

  // -------------------------------------------------------------------------
  // Scoreboard: predicts the verdict of each text and checks it on arrival
  // -------------------------------------------------------------------------
  class balance_scoreboard;
    bit                in_str;
    bit                esc_next;
    bit                failed;
    bit [LVL_BITS-1:0] brace_open;
    bit [LVL_BITS-1:0] bracket_open;
    logic              expected_verdicts[$];
    int                n_texts;
    int                n_checked;
    int                n_good;
    int                n_errors;
    int                deepest;

    function void clear_text();
      in_str       = 1'b0;
      esc_next     = 1'b0;
      failed       = 1'b0;
      brace_open   = '0;
      bracket_open = '0;
    endfunction

    // Accepted byte: advance the tracked state, queue a verdict on last.
    function void note_byte(logic [7:0] c, logic last);
      if (in_str) begin
        if (esc_next)                         esc_next = 1'b0;
        else if (c == jbb_pkg::CH_BACKSLASH)  esc_next = 1'b1;
        else if (c == jbb_pkg::CH_QUOTE)      in_str   = 1'b0;
      end else begin
        case (c)
          jbb_pkg::CH_QUOTE: begin
            in_str   = 1'b1;
            esc_next = 1'b0;
          end
          // openers saturate at all-ones and poison the text
          jbb_pkg::CH_LBRACE: begin
            if (&brace_open) failed = 1'b1;
            else brace_open++;
          end
          jbb_pkg::CH_LBRACKET: begin
            if (&bracket_open) failed = 1'b1;
            else bracket_open++;
          end
          // closers at zero stay at zero and poison the text
          jbb_pkg::CH_RBRACE: begin
            if (brace_open == 0) failed = 1'b1;
            else brace_open--;
          end
          jbb_pkg::CH_RBRACKET: begin
            if (bracket_open == 0) failed = 1'b1;
            else bracket_open--;
          end
          default: ;
        endcase
      end
      if (int'(brace_open) > deepest)   deepest = int'(brace_open);
      if (int'(bracket_open) > deepest) deepest = int'(bracket_open);
      if (last) begin
        expected_verdicts.insert(expected_verdicts.size(),
                                 !failed && !in_str &&
                                 brace_open == 0 && bracket_open == 0);
        n_texts++;
        clear_text();
      end
    endfunction

    function void check_verdict(logic got);
      logic want;
      if (expected_verdicts.size() == 0) begin
        $display("%0t ns: unexpected verdict: expected none, actual is_valid=%b",
                 $time, got);
        n_errors++;
        return;
      end
      want = expected_verdicts.pop_front();
      n_checked++;
      if (want === 1'b1) n_good++;
      if (got !== want) begin
        $display("%0t ns: is_valid mismatch: expected %b, actual %b", $time, want, got);
        n_errors++;
      end
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // -------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  jbb_in_if  in_chan ();
  jbb_out_if out_chan ();

  json_bracket_balance_checker #(
    .DEPTH_BITS (LVL_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  balance_scoreboard board = new();

  logic [7:0] text_buf[$];   // text being built, sent by send_text
  int         bytes_sent;
  int         burst_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop; a correct run needs only a small fraction of this.
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Sender
  // -------------------------------------------------------------------------
  // Holds the item until accepted, then may drop valid for a random gap when
  // the current burst runs out. Prediction is updated at the accepting edge.
  task automatic send_byte(input logic [7:0] c, input logic last);
    in_chan.valid     <= 1'b1;
    in_chan.char_in   <= c;
    in_chan.last_byte <= last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    board.note_byte(c, last);
    bytes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(8, 30) : $urandom_range(1, 4))
        @(posedge clk);
      // mostly short bursts, now and then a long unbroken run
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(0, 12);
    end
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
  endtask

  // Sender goes quiet until every queued verdict has come back.
  task automatic drain();
    in_chan.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Appends one byte to the text under construction.
  task automatic add_byte(input logic [7:0] b);
    text_buf.insert(text_buf.size(), b);
  endtask

  task automatic load_string(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // -------------------------------------------------------------------------
  // Text generators
  // -------------------------------------------------------------------------
  // Quoted string with random content; quotes and backslashes in the body are
  // always escaped, other bytes are escaped now and then.
  task automatic push_string();
    logic [7:0] b;
    add_byte(jbb_pkg::CH_QUOTE);
    repeat ($urandom_range(0, 6)) begin
      b = 8'($urandom_range(0, 255));
      if (b == jbb_pkg::CH_QUOTE || b == jbb_pkg::CH_BACKSLASH ||
          $urandom_range(0, 3) == 0)
        add_byte(jbb_pkg::CH_BACKSLASH);
      add_byte(b);
    end
    add_byte(jbb_pkg::CH_QUOTE);
  endtask

  // Balanced text: nested openers and closers, strings, filler bytes.
  task automatic build_balanced(input int max_depth, input int steps);
    bit         open_kind[$];  // 0: brace, 1: bracket
    logic [7:0] b;
    text_buf.delete();
    repeat ($urandom_range(1, steps)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          if (open_kind.size() < max_depth) begin
            open_kind.insert(open_kind.size(), 1'($urandom_range(0, 1)));
            add_byte(open_kind[$] ? jbb_pkg::CH_LBRACKET : jbb_pkg::CH_LBRACE);
          end
        end
        3, 4: begin
          if (open_kind.size() > 0) begin
            add_byte(open_kind[$] ? jbb_pkg::CH_RBRACKET : jbb_pkg::CH_RBRACE);
            open_kind.delete(open_kind.size() - 1);
          end
        end
        5, 6: push_string();
        default: begin
          // filler; a stray backslash outside a string is harmless
          b = 8'($urandom_range(0, 255));
          if (b == jbb_pkg::CH_QUOTE || b == jbb_pkg::CH_LBRACE ||
              b == jbb_pkg::CH_RBRACE || b == jbb_pkg::CH_LBRACKET ||
              b == jbb_pkg::CH_RBRACKET)
            b = 8'h2C;
          add_byte(b);
        end
      endcase
    end
    while (open_kind.size() > 0) begin
      add_byte(open_kind[$] ? jbb_pkg::CH_RBRACKET : jbb_pkg::CH_RBRACE);
      open_kind.delete(open_kind.size() - 1);
    end
    if (text_buf.size() == 0) add_byte(8'h30);
  endtask

  function automatic logic [7:0] pick_special();
    case ($urandom_range(0, 5))
      0:       return jbb_pkg::CH_QUOTE;
      1:       return jbb_pkg::CH_BACKSLASH;
      2:       return jbb_pkg::CH_LBRACE;
      3:       return jbb_pkg::CH_RBRACE;
      4:       return jbb_pkg::CH_LBRACKET;
      default: return jbb_pkg::CH_RBRACKET;
    endcase
  endfunction

  // Broken text: a balanced one with a few edits, or plain noise.
  task automatic build_broken();
    int idx;
    if ($urandom_range(0, 3) == 0) begin
      text_buf.delete();
      repeat ($urandom_range(1, 12))
        add_byte($urandom_range(0, 1) ? pick_special() : 8'($urandom_range(0, 255)));
    end else begin
      build_balanced($urandom_range(1, 5), $urandom_range(3, 16));
      repeat ($urandom_range(1, 3)) begin
        idx = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 2))
          0: if (text_buf.size() > 1) text_buf.delete(idx);
          1: text_buf.insert(idx, pick_special());
          default: text_buf[idx] = 8'($urandom_range(0, 255));
        endcase
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Receiver: checks each accepted verdict, stalls on a shifting pattern
  // -------------------------------------------------------------------------
  initial begin
    int stall_mode;
    int mode_left;
    int tick;
    stall_mode = 0;
    mode_left  = 50;
    tick       = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready)
        board.check_verdict(out_chan.is_valid);
      tick++;
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       out_chan.ready <= 1'b1;                        // no stalls
        1:       out_chan.ready <= 1'($urandom_range(0, 1));    // coin toss
        2:       out_chan.ready <= ($urandom_range(0, 4) == 0); // mostly held off
        default: out_chan.ready <= ((tick % 7) < 3);            // fixed rhythm
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    in_chan.valid     <= 1'b0;
    in_chan.char_in   <= 8'h00;
    in_chan.last_byte <= 1'b0;
    rst_n             <= 1'b0;
    bytes_sent = 0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed texts ---
    load_string("{}");                send_text();
    load_string("[]");                send_text();
    load_string("}");                 send_text();  // brace closer at zero
    load_string("]");                 send_text();  // bracket closer at zero
    load_string("}{");                send_text();  // failure is sticky
    load_string("{");                 send_text();  // unclosed brace
    load_string("[{]}");              send_text();  // levels are independent
    load_string("\"");                send_text();  // unclosed string
    load_string("\"a\\\"{\"");        send_text();  // escaped quote, brace in string
    load_string("\"\\\\\"");          send_text();  // escaped backslash
    load_string("\"\\");              send_text();  // text ends on an escape
    load_string("\\\"\"");            send_text();  // backslash outside a string
    load_string("\"}]\"");            send_text();  // closers inside a string
    text_buf = '{8'h00};              send_text();
    text_buf = '{8'hFF};              send_text();
    // deepest legal brace nesting, then bracket openers one past the limit
    text_buf.delete();
    repeat ((1 << LVL_BITS) - 1) add_byte(jbb_pkg::CH_LBRACE);
    repeat ((1 << LVL_BITS) - 1) add_byte(jbb_pkg::CH_RBRACE);
    send_text();
    text_buf.delete();
    repeat (1 << LVL_BITS) add_byte(jbb_pkg::CH_LBRACKET);
    send_text();

    // let the pipeline run dry before the random phase
    drain();
    bytes_sent = 0;

    // --- random texts: mostly balanced, the rest damaged or noise ---
    while (bytes_sent < RAND_BYTES) begin
      if ($urandom_range(0, 99) < 65) begin
        if ($urandom_range(0, 19) == 0) build_balanced(40, 120);
        else build_balanced($urandom_range(1, 6), $urandom_range(1, 24));
      end else begin
        build_broken();
      end
      send_text();
      if ($urandom_range(0, 24) == 0) drain();
    end

    drain();
    repeat (10) @(posedge clk);

    $display("Checked %0d verdicts over %0d texts (%0d valid, %0d invalid).",
             board.n_checked, board.n_texts, board.n_good,
             board.n_checked - board.n_good);
    $display("Deepest nesting reached: %0d; mismatches: %0d.",
             board.deepest, board.n_errors);
    if (board.n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
